### design/a2u_pkg.sv
// Shared types and constants of the ASCII to unsigned converter.
`default_nettype none
package a2u_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned CONSUMED_W = 16;
  localparam int unsigned BASE_W     = 6;
  localparam int unsigned DIGIT_W    = 6;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] LETTER_OFFSET = 8'd10;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  typedef struct packed {
    logic [7:0]        char_byte;
    logic              first_char;
    logic [BASE_W-1:0] base;
  } src_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0]    value;
    logic [CONSUMED_W-1:0] consumed;
  } res_word_t;

  // Character after classification, as the back end sees it.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               digit_ok;
    logic               is_x;
    logic               is_space;
    logic               is_zero;
    logic               first_char;
    logic [BASE_W-1:0]  base;
  } cls_word_t;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_ZERO,
    PH_ZERO16,
    PH_XSEEN,
    PH_FIRST,
    PH_MORE,
    PH_DONE
  } phase_t;

endpackage
`default_nettype wire

### design/a2u_front.sv
// Front end: classify each incoming character into digit and flag fields.
`default_nettype none
module a2u_front (
  input  a2u_pkg::src_word_t src_word,
  output a2u_pkg::cls_word_t cls_word
);

  logic [7:0] c;
  logic [7:0] digit_wide;

  assign c = src_word.char_byte;

  always_comb begin
    digit_wide        = 8'd0;
    cls_word.digit_ok = 1'b0;
    if (c >= a2u_pkg::CH_ZERO && c <= a2u_pkg::CH_NINE) begin
      digit_wide        = c - a2u_pkg::CH_ZERO;
      cls_word.digit_ok = 1'b1;
    end else if (c >= a2u_pkg::CH_LA && c <= a2u_pkg::CH_LZ) begin
      digit_wide        = c - a2u_pkg::CH_LA + a2u_pkg::LETTER_OFFSET;
      cls_word.digit_ok = 1'b1;
    end else if (c >= a2u_pkg::CH_UA && c <= a2u_pkg::CH_UZ) begin
      digit_wide        = c - a2u_pkg::CH_UA + a2u_pkg::LETTER_OFFSET;
      cls_word.digit_ok = 1'b1;
    end
    cls_word.digit      = digit_wide[a2u_pkg::DIGIT_W-1:0];
    cls_word.is_x       = (c == a2u_pkg::CH_LX) || (c == a2u_pkg::CH_UX);
    cls_word.is_space   = (c == a2u_pkg::CH_SPACE) || (c == a2u_pkg::CH_TAB);
    cls_word.is_zero    = (c == a2u_pkg::CH_ZERO);
    cls_word.first_char = src_word.first_char;
    cls_word.base       = src_word.base;
  end

endmodule
`default_nettype wire

### design/a2u_queue.sv
// Short queue of classified characters between front and back end.
`default_nettype none
module a2u_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  a2u_pkg::cls_word_t push_word,
  output logic               pop_valid,
  input  logic               pop_ready,
  output a2u_pkg::cls_word_t pop_word
);

  a2u_pkg::cls_word_t entry [a2u_pkg::QDEPTH];
  logic [a2u_pkg::QPTR_W-1:0] wr_ptr;
  logic [a2u_pkg::QPTR_W-1:0] rd_ptr;
  logic [a2u_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != a2u_pkg::QCNT_W'(a2u_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_word   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [a2u_pkg::QPTR_W-1:0] wrap_inc(
    input logic [a2u_pkg::QPTR_W-1:0] p
  );
    logic [a2u_pkg::QPTR_W-1:0] r;
    if (p == a2u_pkg::QPTR_W'(a2u_pkg::QDEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wrap_inc(wr_ptr);
      if (do_pop) rd_ptr <= wrap_inc(rd_ptr);
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/a2u_back.sv
// Back end: parse state machine, accumulator and result register.
`default_nettype none
module a2u_back #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cls_valid,
  output logic               cls_ready,
  input  a2u_pkg::cls_word_t cls_word,
  output logic               res_valid,
  input  logic               res_ready,
  output a2u_pkg::res_word_t res_word
);

  localparam int unsigned PROD_W = VALUE_BITS + a2u_pkg::BASE_W;

  a2u_pkg::phase_t             phase, phase_next;
  logic [VALUE_BITS-1:0]       accumulator, accumulator_next;
  logic [a2u_pkg::BASE_W-1:0]  active_base, active_base_next;
  logic [COUNT_BITS-1:0]       char_count, char_count_next;

  logic                        emit;
  logic                        do_digit;
  logic [VALUE_BITS-1:0]       emit_value;
  logic [COUNT_BITS-1:0]       emit_count;
  logic [PROD_W-1:0]           prod;
  logic [a2u_pkg::VALUE_W-1:0] value_wide;
  logic [31:0]                 count_wide;
  logic                        pop;

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] n);
    logic [COUNT_BITS-1:0] r;
    if (n == '1) r = n;
    else r = n + 1'b1;
    return r;
  endfunction

  assign pop       = cls_valid && (!res_valid || res_ready);
  assign cls_ready = !res_valid || res_ready;

  always_comb begin
    phase_next       = phase;
    accumulator_next = accumulator;
    active_base_next = active_base;
    char_count_next  = char_count;
    // A start flag restarts the string and samples its base.
    if (cls_word.first_char) begin
      phase_next       = a2u_pkg::PH_SKIP;
      accumulator_next = '0;
      active_base_next = cls_word.base;
      char_count_next  = '0;
    end
    emit       = 1'b0;
    emit_value = '0;
    emit_count = '0;
    do_digit   = 1'b0;
    prod       = '0;

    unique case (phase_next)
      a2u_pkg::PH_SKIP: begin
        if (active_base_next == a2u_pkg::BASE_ONE || active_base_next > a2u_pkg::BASE_MAX) begin
          emit       = 1'b1;
          phase_next = a2u_pkg::PH_DONE;
        end else if (cls_word.is_space) begin
          char_count_next = count_up(char_count_next);
        end else if (cls_word.is_zero && (active_base_next == a2u_pkg::BASE_AUTO ||
                                          active_base_next == a2u_pkg::BASE_HEX)) begin
          char_count_next = count_up(char_count_next);
          phase_next = (active_base_next == a2u_pkg::BASE_AUTO) ? a2u_pkg::PH_ZERO
                                                                : a2u_pkg::PH_ZERO16;
        end else begin
          if (active_base_next == a2u_pkg::BASE_AUTO) active_base_next = a2u_pkg::BASE_DEC;
          phase_next = a2u_pkg::PH_FIRST;
          do_digit   = 1'b1;
        end
      end
      a2u_pkg::PH_ZERO: begin
        if (cls_word.is_x) begin
          active_base_next = a2u_pkg::BASE_HEX;
          phase_next       = a2u_pkg::PH_XSEEN;
        end else begin
          active_base_next = a2u_pkg::BASE_OCT;
          phase_next       = a2u_pkg::PH_MORE;
          do_digit         = 1'b1;
        end
      end
      a2u_pkg::PH_ZERO16: begin
        if (cls_word.is_x) begin
          phase_next = a2u_pkg::PH_XSEEN;
        end else begin
          phase_next = a2u_pkg::PH_MORE;
          do_digit   = 1'b1;
        end
      end
      a2u_pkg::PH_XSEEN: begin
        // Prefix without a hex digit: report the lone zero.
        if (!cls_word.digit_ok || cls_word.digit >= a2u_pkg::DIGIT_W'(a2u_pkg::BASE_HEX)) begin
          emit       = 1'b1;
          emit_count = char_count_next;
          phase_next = a2u_pkg::PH_DONE;
        end else begin
          char_count_next = count_up(char_count_next);
          phase_next      = a2u_pkg::PH_MORE;
          do_digit        = 1'b1;
        end
      end
      a2u_pkg::PH_FIRST, a2u_pkg::PH_MORE: begin
        do_digit = 1'b1;
      end
      a2u_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (do_digit) begin
      if (cls_word.digit_ok && cls_word.digit < active_base_next) begin
        prod = {{a2u_pkg::BASE_W{1'b0}}, accumulator_next} *
               {{VALUE_BITS{1'b0}}, active_base_next};
        accumulator_next = prod[VALUE_BITS-1:0] + VALUE_BITS'(cls_word.digit);
        char_count_next  = count_up(char_count_next);
        phase_next       = a2u_pkg::PH_MORE;
      end else begin
        emit = 1'b1;
        if (phase_next == a2u_pkg::PH_MORE) begin
          emit_value = accumulator_next;
          emit_count = char_count_next;
        end
        phase_next = a2u_pkg::PH_DONE;
      end
    end
  end

  assign value_wide = a2u_pkg::VALUE_W'(emit_value);
  assign count_wide = 32'(emit_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= a2u_pkg::PH_SKIP;
      accumulator <= '0;
      active_base <= a2u_pkg::BASE_DEC;
      char_count  <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        accumulator <= accumulator_next;
        active_base <= active_base_next;
        char_count  <= char_count_next;
        res_valid   <= emit;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_word.value    <= value_wide;
      res_word.consumed <= count_wide[a2u_pkg::CONSUMED_W-1:0];
    end
  end

endmodule
`default_nettype wire

### design/ascii_to_unsigned_any_base.sv
// Top level of the ASCII to unsigned converter in bases 2 to 36 or auto.
//
//   channel  direction  handshake              word
//   src      in         src_valid/src_ready    char_byte, first_char, base
//   res      out        res_valid/res_ready    value, consumed
//
// Flow: one character word per cycle while the back end is not held by a
//   waiting result; an accepted character is written into the queue, and a
//   result is registered, raising res_valid, at the edge that pops its
//   terminating character from the queue.
// The combinational multiply-add on the accumulator in the back end sets
//   the rate: one character is folded in per cycle while no result waits.
// Reset: synchronous rst clears the queue, empties the result register and
//   puts the parser in its whitespace phase with base ten.
// Stalls: a two-entry queue parts front and back; src_ready drops only
//   when the queue is full, and the back end holds while a result waits.
`default_nettype none
module ascii_to_unsigned_any_base #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  a2u_pkg::src_word_t src_word,
  output logic               res_valid,
  input  logic               res_ready,
  output a2u_pkg::res_word_t res_word
);

  a2u_pkg::cls_word_t front_word;
  a2u_pkg::cls_word_t back_word;
  logic               back_valid;
  logic               back_ready;

  // Classify the raw byte as it arrives.
  a2u_front u_front (
    .src_word (src_word),
    .cls_word (front_word)
  );

  // Hold classified words so either side can stall on its own.
  a2u_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (src_valid),
    .push_ready (src_ready),
    .push_word  (front_word),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_word   (back_word)
  );

  // Advance the parser and register any result.
  a2u_back #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (back_valid),
    .cls_ready (back_ready),
    .cls_word  (back_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

endmodule
`default_nettype wire

### tb/sv/tb_ascii_to_unsigned_any_base.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ASCII to unsigned converter.
module tb_ascii_to_unsigned_any_base;

  // Random part length and quiet tail length.
  localparam int unsigned RAND_ITEMS = 650;
  localparam int unsigned TAIL_LEN   = 60;

  localparam logic [6:0]                     NOT_DIGIT = 7'd99;
  localparam logic [a2u_pkg::CONSUMED_W-1:0] COUNT_CAP = '1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TOP   = 8'hFF;

  // One character word waiting to be driven, with its idle gap and a flag
  // that holds it back until every pending number has come out.
  typedef struct packed {
    a2u_pkg::src_word_t w;
    logic [4:0]         gap;
    logic               drain;
  } char_slot_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               src_valid = 1'b0;
  logic               src_ready;
  a2u_pkg::src_word_t src_word  = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  a2u_pkg::res_word_t res_word;

  ascii_to_unsigned_any_base dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_word  (src_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Parser shadow: its own phase, accumulator, base and count.
  // ---------------------------------------------------------------------
  a2u_pkg::phase_t                prs_phase = a2u_pkg::PH_SKIP;
  logic [a2u_pkg::VALUE_W-1:0]    prs_acc   = '0;
  logic [a2u_pkg::BASE_W-1:0]     prs_base  = a2u_pkg::BASE_DEC;
  logic [a2u_pkg::CONSUMED_W-1:0] prs_count = '0;

  a2u_pkg::res_word_t parsed_q[$];   // numbers the parser must still emit, oldest first
  char_slot_t         char_q[$];     // character words not yet driven

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    if (c >= a2u_pkg::CH_ZERO && c <= a2u_pkg::CH_NINE) return 7'(c - a2u_pkg::CH_ZERO);
    if (c >= a2u_pkg::CH_LA && c <= a2u_pkg::CH_LZ)
      return 7'(c - a2u_pkg::CH_LA + a2u_pkg::LETTER_OFFSET);
    if (c >= a2u_pkg::CH_UA && c <= a2u_pkg::CH_UZ)
      return 7'(c - a2u_pkg::CH_UA + a2u_pkg::LETTER_OFFSET);
    return NOT_DIGIT;
  endfunction

  task automatic bump_count();
    if (prs_count != COUNT_CAP) prs_count = prs_count + 1'b1;
  endtask

  // Queue one converted number and stop the string.
  task automatic post_result(input logic [a2u_pkg::VALUE_W-1:0] v,
                             input logic [a2u_pkg::CONSUMED_W-1:0] n);
    a2u_pkg::res_word_t r;
    r.value    = v;
    r.consumed = n;
    parsed_q.push_back(r);
    prs_phase = a2u_pkg::PH_DONE;
  endtask

  // Advance the parser shadow by one accepted character word.
  task automatic fold_char(input a2u_pkg::src_word_t w);
    logic [6:0] d;
    logic       is_x;
    logic       go;
    d    = digit_of(w.char_byte);
    is_x = (w.char_byte == a2u_pkg::CH_LX) || (w.char_byte == a2u_pkg::CH_UX);
    go   = 1'b1;
    // A start flag drops any unfinished number and samples the base.
    if (w.first_char) begin
      prs_phase = a2u_pkg::PH_SKIP;
      prs_acc   = '0;
      prs_count = '0;
      prs_base  = w.base;
    end
    case (prs_phase)
      a2u_pkg::PH_SKIP: begin
        if (prs_base == a2u_pkg::BASE_ONE || prs_base > a2u_pkg::BASE_MAX) begin
          // invalid base: convert nothing
          post_result('0, '0);
          go = 1'b0;
        end else if (w.char_byte == a2u_pkg::CH_SPACE || w.char_byte == a2u_pkg::CH_TAB) begin
          bump_count();
          go = 1'b0;
        end else if (w.char_byte == a2u_pkg::CH_ZERO &&
                     (prs_base == a2u_pkg::BASE_AUTO || prs_base == a2u_pkg::BASE_HEX)) begin
          bump_count();
          prs_phase = (prs_base == a2u_pkg::BASE_AUTO) ? a2u_pkg::PH_ZERO
                                                      : a2u_pkg::PH_ZERO16;
          go = 1'b0;
        end else begin
          if (prs_base == a2u_pkg::BASE_AUTO) prs_base = a2u_pkg::BASE_DEC;
          prs_phase = a2u_pkg::PH_FIRST;
        end
      end
      a2u_pkg::PH_ZERO: begin
        if (is_x) begin
          prs_base  = a2u_pkg::BASE_HEX;
          prs_phase = a2u_pkg::PH_XSEEN;
          go = 1'b0;
        end else begin
          prs_base  = a2u_pkg::BASE_OCT;
          prs_phase = a2u_pkg::PH_MORE;
        end
      end
      a2u_pkg::PH_ZERO16: begin
        if (is_x) begin
          prs_phase = a2u_pkg::PH_XSEEN;
          go = 1'b0;
        end else begin
          prs_phase = a2u_pkg::PH_MORE;
        end
      end
      a2u_pkg::PH_XSEEN: begin
        // "0x" with no hex digit after it reads as the lone zero
        if (d >= 7'd16) begin
          post_result('0, prs_count);
          go = 1'b0;
        end else begin
          bump_count();
          prs_phase = a2u_pkg::PH_MORE;
        end
      end
      a2u_pkg::PH_FIRST, a2u_pkg::PH_MORE: ;
      default: go = 1'b0;   // number already out: ignore the rest
    endcase
    if (go) begin
      if (d < prs_base) begin
        prs_acc = prs_acc * a2u_pkg::VALUE_W'(prs_base) + a2u_pkg::VALUE_W'(d);
        bump_count();
        prs_phase = a2u_pkg::PH_MORE;
      end else if (prs_phase == a2u_pkg::PH_MORE) begin
        post_result(prs_acc, prs_count);
      end else begin
        post_result('0, '0);   // no digit at all
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------
  logic        gen_jitter = 1'b1;
  logic        gen_drain  = 1'b0;
  logic        counting   = 1'b0;
  int unsigned rand_items = 0;
  int unsigned strings    = 0;

  task automatic push_char(input logic [7:0] c, input logic first,
                           input logic [a2u_pkg::BASE_W-1:0] b);
    char_slot_t s;
    s.w.char_byte  = c;
    s.w.first_char = first;
    s.w.base       = b;
    s.gap          = '0;
    // Keep the last stretch of the run free of sender gaps.
    if (gen_jitter && rand_items + TAIL_LEN < RAND_ITEMS && $urandom_range(0, 5) == 0)
      s.gap = 5'($urandom_range(1, 19));
    s.drain   = gen_drain;
    gen_drain = 1'b0;
    char_q.push_back(s);
    if (counting) rand_items++;
  endtask

  task automatic push_text(input string s, input logic [a2u_pkg::BASE_W-1:0] b,
                           input logic start);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], start && (i == 0), b);
  endtask

  function automatic logic [7:0] glyph(input int unsigned d);
    if (d < 10) return a2u_pkg::CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? a2u_pkg::CH_LA : a2u_pkg::CH_UA) + 8'(d - 10);
  endfunction

  // Build one well-formed string with random content: optional whitespace,
  // optional prefix, digits below the base, then a terminator (or none).
  task automatic make_number();
    logic [a2u_pkg::BASE_W-1:0] b;
    logic [7:0]                 txt[$];
    int unsigned                radix;
    int unsigned                n;
    int unsigned                pick;
    pick = $urandom_range(0, 19);
    if (pick < 6)        b = a2u_pkg::BASE_AUTO;
    else if (pick < 9)   b = a2u_pkg::BASE_HEX;
    else if (pick < 18)  b = 6'($urandom_range(2, 36));
    else if (pick == 18) b = $urandom_range(0, 1) ? a2u_pkg::BASE_ONE
                                                  : 6'($urandom_range(37, 63));
    else                 b = a2u_pkg::BASE_DEC;
    radix = (b == a2u_pkg::BASE_AUTO || b == a2u_pkg::BASE_ONE || b > a2u_pkg::BASE_MAX)
            ? 10 : int'(b);

    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) txt.push_back($urandom_range(0, 1) ? a2u_pkg::CH_SPACE : a2u_pkg::CH_TAB);

    if (b == a2u_pkg::BASE_AUTO) begin
      pick = $urandom_range(0, 3);
      if (pick == 1) begin
        txt.push_back(a2u_pkg::CH_ZERO);
        radix = 8;
      end else if (pick >= 2) begin
        txt.push_back(a2u_pkg::CH_ZERO);
        txt.push_back($urandom_range(0, 1) ? a2u_pkg::CH_LX : a2u_pkg::CH_UX);
        radix = 16;
      end
    end else if (b == a2u_pkg::BASE_HEX && $urandom_range(0, 1)) begin
      txt.push_back(a2u_pkg::CH_ZERO);
      txt.push_back($urandom_range(0, 1) ? a2u_pkg::CH_LX : a2u_pkg::CH_UX);
    end

    // Long digit runs wrap the 64-bit value in most bases.
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 26) : $urandom_range(0, 8);
    repeat (n) txt.push_back(glyph($urandom_range(0, radix - 1)));

    case ($urandom_range(0, 11))
      0:       txt.push_back(a2u_pkg::CH_SPACE);
      1:       txt.push_back(CH_COMMA);
      2:       txt.push_back(CH_NUL);
      3:       txt.push_back(CH_MINUS);
      4:       txt.push_back(CH_PLUS);
      5:       txt.push_back(radix < 36 ? glyph($urandom_range(radix, 35)) : CH_TOP);
      6, 7:    txt.push_back(8'($urandom_range(0, 255)));
      8:       txt.push_back(a2u_pkg::CH_LX);
      9:       txt.push_back(CH_TOP);
      10:      txt.push_back(a2u_pkg::CH_TAB);
      default: ;   // leave it unfinished; the next start flag drops it
    endcase

    for (int i = 0; i < txt.size(); i++)
      push_char(txt[i], i == 0, b);

    // Characters after a finished number are ignored by the block.
    if ($urandom_range(0, 4) == 0) begin
      counting = 1'b0;
      repeat ($urandom_range(1, 2))
        push_char(8'($urandom_range(0, 255)), 1'b0, 6'($urandom_range(0, 63)));
      counting = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: present queued words, hold them until taken, predict on accept.
  // ---------------------------------------------------------------------
  logic        tail = 1'b0;
  logic [4:0]  idle_run = '0;
  char_slot_t  next_slot;
  int unsigned chars_taken = 0;

  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
      idle_run  <= '0;
      prs_phase = a2u_pkg::PH_SKIP;
      prs_acc   = '0;
      prs_base  = a2u_pkg::BASE_DEC;
      prs_count = '0;
    end else begin
      if (src_valid && src_ready) begin
        fold_char(src_word);
        chars_taken++;
      end
      // Advance only when the current word is gone or none was offered.
      if (!src_valid || src_ready) begin
        if (char_q.size() == 0) begin
          src_valid <= 1'b0;
        end else begin
          next_slot = char_q[0];
          if (next_slot.drain && parsed_q.size() != 0) begin
            src_valid <= 1'b0;   // hold off until every number is out
          end else if (idle_run < next_slot.gap) begin
            idle_run  <= idle_run + 1'b1;
            src_valid <= 1'b0;
          end else begin
            next_slot = char_q.pop_front();
            src_word  <= next_slot.w;
            src_valid <= 1'b1;
            idle_run  <= '0;
          end
        end
      end
      tail <= (char_q.size() < TAIL_LEN);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each taken result, stall the result side in bursts.
  // ---------------------------------------------------------------------
  int unsigned        errors     = 0;
  int unsigned        results_ok = 0;
  logic [4:0]         stall_left = '0;
  int unsigned        calm_left  = 0;
  int unsigned        rx_pick;
  logic               rx_take;
  a2u_pkg::res_word_t want;

  always @(posedge clk) begin
    if (rst) begin
      res_ready  <= 1'b0;
      stall_left <= '0;
      calm_left  <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (parsed_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got value=%0h consumed=%0d",
                   $time, res_word.value, res_word.consumed);
          errors++;
        end else begin
          want = parsed_q.pop_front();
          if (res_word.value !== want.value) begin
            $display("%0t: value mismatch: expected %0h, got %0h",
                     $time, want.value, res_word.value);
            errors++;
          end
          if (res_word.consumed !== want.consumed) begin
            $display("%0t: consumed mismatch: expected %0d, got %0d",
                     $time, want.consumed, res_word.consumed);
            errors++;
          end
          if (res_word === want) results_ok++;
        end
      end
      // Stall bursts, calm stretches, none in the tail.
      if (tail) begin
        rx_take = 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1'b1;
        rx_take = 1'b0;
      end else if (calm_left != 0) begin
        calm_left <= calm_left - 1;
        rx_take = 1'b1;
      end else begin
        rx_pick = $urandom_range(0, 39);
        if (rx_pick < 4) begin
          stall_left <= 5'($urandom_range(0, 18));
          rx_take = 1'b0;
        end else if (rx_pick == 4) begin
          calm_left <= $urandom_range(50, 200);
          rx_take = 1'b1;
        end else begin
          rx_take = 1'b1;
        end
      end
      res_ready <= rx_take;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    // Directed strings. The first one runs with no start flag, so the
    // block must parse it in base ten straight out of reset.
    push_text("12 ", a2u_pkg::BASE_DEC, 1'b0);
    push_text("\t0x1F;", a2u_pkg::BASE_AUTO, 1'b1);     // whitespace, auto hex
    push_text("017,", a2u_pkg::BASE_AUTO, 1'b1);        // auto octal
    push_text("0xg", a2u_pkg::BASE_HEX, 1'b1);          // prefix with no hex digit
    push_text("Z", a2u_pkg::BASE_MAX, 1'b1);
    push_char(CH_TOP, 1'b0, a2u_pkg::BASE_MAX);         // top byte ends it
    push_text("12", 6'd2, 1'b1);                        // binary, digit above base
    push_text("5", a2u_pkg::BASE_ONE, 1'b1);            // invalid bases
    push_text("7", 6'd63, 1'b1);
    push_text("-5", a2u_pkg::BASE_DEC, 1'b1);           // sign, then an ignored digit
    push_text("+", a2u_pkg::BASE_DEC, 1'b1);
    push_text("9", a2u_pkg::BASE_DEC, 1'b1);            // dropped by the restart
    push_text("7", a2u_pkg::BASE_DEC, 1'b1);
    push_char(CH_NUL, 1'b0, a2u_pkg::BASE_DEC);

    // Random strings; the first waits for the directed results to drain.
    gen_drain = 1'b1;
    counting  = 1'b1;
    while (rand_items < RAND_ITEMS) begin
      gen_jitter = ($urandom_range(0, 3) != 0);
      if (strings % 40 == 0 && rand_items + TAIL_LEN < RAND_ITEMS) gen_drain = 1'b1;
      if ($urandom_range(0, 14) == 0) begin
        // noise: random bytes, random start flags and bases
        repeat ($urandom_range(1, 3))
          push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    6'($urandom_range(0, 63)));
      end else begin
        make_number();
      end
      strings++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last word and the last number, then let the pipe settle.
    while (char_q.size() != 0 || src_valid || parsed_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d characters in %0d random strings plus directed cases; %0d numbers",
             chars_taken, strings, results_ok);
    $display("matched, over bases 0 to 63, prefixes, whitespace, signs and value wrap.");
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
design/a2u_pkg.sv
design/a2u_front.sv
design/a2u_queue.sv
design/a2u_back.sv
design/ascii_to_unsigned_any_base.sv
tb/sv/tb_ascii_to_unsigned_any_base.sv
